// ----- design/mqtt_cs_pkg.sv -----
// types, codes and constants shared by the mqtt connect sniffer files
package mqtt_cs_pkg;

    // parse phases, one-hot
    typedef enum logic [24:0] {
        PH_TYPE   = 25'd1 << 0,
        PH_RLEN   = 25'd1 << 1,
        PH_PN_HI  = 25'd1 << 2,
        PH_PN_LO  = 25'd1 << 3,
        PH_PN     = 25'd1 << 4,
        PH_VER    = 25'd1 << 5,
        PH_FLAGS  = 25'd1 << 6,
        PH_KA     = 25'd1 << 7,
        PH_PLEN   = 25'd1 << 8,
        PH_PSKIP  = 25'd1 << 9,
        PH_CID_HI = 25'd1 << 10,
        PH_CID_LO = 25'd1 << 11,
        PH_CID    = 25'd1 << 12,
        PH_WPLEN  = 25'd1 << 13,
        PH_WPSKIP = 25'd1 << 14,
        PH_WT_HI  = 25'd1 << 15,
        PH_WT_LO  = 25'd1 << 16,
        PH_WT     = 25'd1 << 17,
        PH_WP_HI  = 25'd1 << 18,
        PH_WP_LO  = 25'd1 << 19,
        PH_WP     = 25'd1 << 20,
        PH_UN_HI  = 25'd1 << 21,
        PH_UN_LO  = 25'd1 << 22,
        PH_UN     = 25'd1 << 23,
        PH_DONE   = 25'd1 << 24
    } phase_t;

    // verdict codes
    localparam logic [1:0] VERDICT_PENDING  = 2'd0;
    localparam logic [1:0] VERDICT_ACCEPTED = 2'd1;
    localparam logic [1:0] VERDICT_DECLINED = 2'd2;
    localparam logic [1:0] VERDICT_NEEDMORE = 2'd3;

    // byte role codes
    localparam logic [1:0] ROLE_OTHER    = 2'd0;
    localparam logic [1:0] ROLE_CLIENTID = 2'd1;
    localparam logic [1:0] ROLE_USERNAME = 2'd2;

    // outcome codes
    localparam logic [1:0] OUTCOME_PARSING  = 2'd0;
    localparam logic [1:0] OUTCOME_COMPLETE = 2'd1;
    localparam logic [1:0] OUTCOME_ERR_HEAD = 2'd2;
    localparam logic [1:0] OUTCOME_ERR_BODY = 2'd3;

    // protocol constants
    localparam logic [7:0]  CONNECT_TYPE  = 8'h10;
    localparam logic [3:0]  MIN_BYTES     = 4'd14;
    localparam logic [7:0]  NAME_LEN      = 8'h04;
    localparam logic [7:0]  VERSION_311   = 8'h04;
    localparam logic [7:0]  VERSION_5     = 8'h05;
    localparam int unsigned FLAG_RESERVED = 0;
    localparam int unsigned FLAG_WILL     = 2;
    localparam int unsigned FLAG_USER     = 7;
    localparam logic [27:0] COUNT_MAX     = 28'h0FF_FFFF | 28'hF00_0000;
    localparam logic [1:0]  VARINT_LAST   = 2'd3;

    // one item's result
    typedef struct packed {
        logic [1:0]  verdict;
        logic [1:0]  byte_role;
        logic [7:0]  out_byte;
        logic [15:0] client_id_length;
        logic [15:0] username_length;
        logic        has_username;
    } result_t;

    // characters of the protocol name
    function automatic logic [7:0] proto_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'h4D;
            2'd1:    c = 8'h51;
            default: c = 8'h54;
        endcase
        return c;
    endfunction

    // add one variable-length integer digit at its 7-bit position
    function automatic logic [27:0] varint_add(input logic [27:0] acc,
                                               input logic [7:0]  b,
                                               input logic [1:0]  sh);
        logic [27:0] digit;
        case (sh)
            2'd0:    digit = {21'd0, b[6:0]};
            2'd1:    digit = {14'd0, b[6:0], 7'd0};
            2'd2:    digit = {7'd0, b[6:0], 14'd0};
            default: digit = {b[6:0], 21'd0};
        endcase
        return acc + digit;
    endfunction

endpackage

// ----- design/mqtt_cs_ifs.sv -----
// valid/ready channel interfaces for input bytes and results
interface mqtt_cs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       end_of_data;

    modport source (output valid, output data_byte, output first_byte,
                    output end_of_data, input ready);
    modport sink (input valid, input data_byte, input first_byte,
                  input end_of_data, output ready);
endinterface

interface mqtt_cs_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  verdict;
    logic [1:0]  byte_role;
    logic [7:0]  out_byte;
    logic [15:0] client_id_length;
    logic [15:0] username_length;
    logic        has_username;

    modport source (output valid, output verdict, output byte_role, output out_byte,
                    output client_id_length, output username_length,
                    output has_username, input ready);
    modport sink (input valid, input verdict, input byte_role, input out_byte,
                  input client_id_length, input username_length,
                  input has_username, output ready);
endinterface

// ----- design/mqtt_cs_parser.sv -----
// per-byte connect packet parser: stream state and result logic
module mqtt_cs_parser
    import mqtt_cs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write_en,
    input  logic       cfg_write_data,
    input  logic       accept,
    input  logic [7:0] data_byte,
    input  logic       first_byte,
    input  logic       end_of_data,
    output result_t    result
);

    logic        enable_reg;
    phase_t      phase_reg, phase_next;
    logic [3:0]  total_reg, total_next;
    logic [27:0] rlen_reg, rlen_next;
    logic [27:0] body_reg, body_next;
    logic [1:0]  shift_reg, shift_next;
    logic [27:0] field_reg, field_next;
    logic [7:0]  flags_reg, flags_next;
    logic        v5_reg, v5_next;
    logic [15:0] cid_len_reg, cid_len_next;
    logic [15:0] user_len_reg, user_len_next;
    logic [1:0]  outcome_reg, outcome_next;

    // enable register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            enable_reg <= cfg_write_data;
        end
    end

    // next stream state and result for the byte being transferred
    always_comb
    begin
        phase_t     body_ph;
        logic       str_done;
        logic [1:0] role;
        logic [1:0] verdict;

        phase_next    = phase_reg;
        total_next    = total_reg;
        rlen_next     = rlen_reg;
        body_next     = body_reg;
        shift_next    = shift_reg;
        field_next    = field_reg;
        flags_next    = flags_reg;
        v5_next       = v5_reg;
        cid_len_next  = cid_len_reg;
        user_len_next = user_len_reg;
        outcome_next  = outcome_reg;
        body_ph       = PH_DONE;
        str_done      = 1'b0;
        role          = ROLE_OTHER;
        verdict       = VERDICT_PENDING;

        // new connection restarts the parser
        if (first_byte)
        begin
            phase_next    = PH_TYPE;
            total_next    = '0;
            rlen_next     = '0;
            body_next     = '0;
            shift_next    = '0;
            field_next    = '0;
            flags_next    = '0;
            v5_next       = 1'b0;
            cid_len_next  = '0;
            user_len_next = '0;
            outcome_next  = OUTCOME_PARSING;
        end

        // byte counters
        if (total_next < MIN_BYTES)
        begin
            total_next = total_next + 4'd1;
        end
        if (phase_next != PH_TYPE && phase_next != PH_RLEN && body_next != COUNT_MAX)
        begin
            body_next = body_next + 28'd1;
        end

        // phase step
        case (phase_next)
            PH_TYPE:
            begin
                if (data_byte != CONNECT_TYPE)
                begin
                    outcome_next = OUTCOME_ERR_HEAD;
                    phase_next   = PH_DONE;
                end
                else
                begin
                    rlen_next  = '0;
                    shift_next = '0;
                    phase_next = PH_RLEN;
                end
            end
            PH_RLEN:
            begin
                rlen_next = varint_add(rlen_next, data_byte, shift_next);
                if (!data_byte[7])
                begin
                    phase_next = PH_PN_HI;
                end
                else if (shift_next == VARINT_LAST)
                begin
                    outcome_next = OUTCOME_ERR_HEAD;
                    phase_next   = PH_DONE;
                end
                else
                begin
                    shift_next = shift_next + 2'd1;
                end
            end
            PH_PN_HI:
            begin
                if (data_byte != 8'd0)
                begin
                    outcome_next = OUTCOME_ERR_BODY;
                    phase_next   = PH_DONE;
                end
                else
                begin
                    phase_next = PH_PN_LO;
                end
            end
            PH_PN_LO:
            begin
                if (data_byte != NAME_LEN)
                begin
                    outcome_next = OUTCOME_ERR_BODY;
                    phase_next   = PH_DONE;
                end
                else
                begin
                    field_next = '0;
                    phase_next = PH_PN;
                end
            end
            PH_PN:
            begin
                if (data_byte != proto_char(field_next[1:0]))
                begin
                    outcome_next = OUTCOME_ERR_BODY;
                    phase_next   = PH_DONE;
                end
                else
                begin
                    field_next = field_next + 28'd1;
                    if (field_next >= 28'd4)
                    begin
                        phase_next = PH_VER;
                    end
                end
            end
            PH_VER:
            begin
                if (data_byte == VERSION_311)
                begin
                    v5_next    = 1'b0;
                    phase_next = PH_FLAGS;
                end
                else if (data_byte == VERSION_5)
                begin
                    v5_next    = 1'b1;
                    phase_next = PH_FLAGS;
                end
                else
                begin
                    outcome_next = OUTCOME_ERR_BODY;
                    phase_next   = PH_DONE;
                end
            end
            PH_FLAGS:
            begin
                flags_next = data_byte;
                if (data_byte[FLAG_RESERVED])
                begin
                    outcome_next = OUTCOME_ERR_BODY;
                    phase_next   = PH_DONE;
                end
                else
                begin
                    field_next = '0;
                    phase_next = PH_KA;
                end
            end
            PH_KA:
            begin
                field_next = field_next + 28'd1;
                if (field_next >= 28'd2)
                begin
                    if (v5_next)
                    begin
                        field_next = '0;
                        shift_next = '0;
                        phase_next = PH_PLEN;
                    end
                    else
                    begin
                        phase_next = PH_CID_HI;
                    end
                end
            end
            PH_PLEN, PH_WPLEN:
            begin
                field_next = varint_add(field_next, data_byte, shift_next);
                if (!data_byte[7])
                begin
                    if (phase_next == PH_PLEN)
                    begin
                        phase_next = (field_next == '0) ? PH_CID_HI : PH_PSKIP;
                    end
                    else
                    begin
                        phase_next = (field_next == '0) ? PH_WT_HI : PH_WPSKIP;
                    end
                end
                else if (shift_next == VARINT_LAST)
                begin
                    outcome_next = OUTCOME_ERR_BODY;
                    phase_next   = PH_DONE;
                end
                else
                begin
                    shift_next = shift_next + 2'd1;
                end
            end
            PH_PSKIP, PH_WPSKIP:
            begin
                field_next = field_next - 28'd1;
                if (field_next == '0)
                begin
                    phase_next = (phase_next == PH_PSKIP) ? PH_CID_HI : PH_WT_HI;
                end
            end
            PH_CID_HI:
            begin
                field_next = {12'd0, data_byte, 8'd0};
                phase_next = PH_CID_LO;
            end
            PH_WT_HI:
            begin
                field_next = {12'd0, data_byte, 8'd0};
                phase_next = PH_WT_LO;
            end
            PH_WP_HI:
            begin
                field_next = {12'd0, data_byte, 8'd0};
                phase_next = PH_WP_LO;
            end
            PH_UN_HI:
            begin
                field_next = {12'd0, data_byte, 8'd0};
                phase_next = PH_UN_LO;
            end
            PH_CID_LO, PH_WT_LO, PH_WP_LO, PH_UN_LO:
            begin
                field_next = field_next | {20'd0, data_byte};
                case (phase_next)
                    PH_CID_LO:
                    begin
                        body_ph      = PH_CID;
                        cid_len_next = field_next[15:0];
                    end
                    PH_WT_LO: body_ph = PH_WT;
                    PH_WP_LO: body_ph = PH_WP;
                    default:
                    begin
                        body_ph       = PH_UN;
                        user_len_next = field_next[15:0];
                    end
                endcase
                if (field_next == '0)
                begin
                    str_done = 1'b1;
                end
                else
                begin
                    phase_next = body_ph;
                end
            end
            PH_CID, PH_WT, PH_WP, PH_UN:
            begin
                if (phase_next == PH_CID)
                begin
                    role = ROLE_CLIENTID;
                end
                if (phase_next == PH_UN)
                begin
                    role = ROLE_USERNAME;
                end
                body_ph    = phase_next;
                field_next = field_next - 28'd1;
                if (field_next == '0)
                begin
                    str_done = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase

        // move on after a string has been fully read
        if (str_done)
        begin
            case (body_ph)
                PH_CID:
                begin
                    if (!flags_next[FLAG_USER])
                    begin
                        outcome_next = OUTCOME_COMPLETE;
                        phase_next   = PH_DONE;
                    end
                    else if (flags_next[FLAG_WILL])
                    begin
                        if (v5_next)
                        begin
                            field_next = '0;
                            shift_next = '0;
                            phase_next = PH_WPLEN;
                        end
                        else
                        begin
                            phase_next = PH_WT_HI;
                        end
                    end
                    else
                    begin
                        phase_next = PH_UN_HI;
                    end
                end
                PH_WT:   phase_next = PH_WP_HI;
                PH_WP:   phase_next = PH_UN_HI;
                default:
                begin
                    outcome_next = OUTCOME_COMPLETE;
                    phase_next   = PH_DONE;
                end
            endcase
        end

        // verdict on the last buffered byte
        if (end_of_data)
        begin
            if (!enable_reg)
            begin
                verdict = VERDICT_DECLINED;
            end
            else if (total_next < MIN_BYTES)
            begin
                verdict = VERDICT_NEEDMORE;
            end
            else if (outcome_next == OUTCOME_ERR_HEAD)
            begin
                verdict = VERDICT_DECLINED;
            end
            else if (body_next < rlen_next)
            begin
                verdict = VERDICT_NEEDMORE;
            end
            else if (outcome_next == OUTCOME_COMPLETE)
            begin
                verdict = VERDICT_ACCEPTED;
            end
            else
            begin
                verdict = VERDICT_DECLINED;
            end
        end

        result.verdict   = verdict;
        result.byte_role = role;
        result.out_byte  = data_byte;
        if (verdict == VERDICT_ACCEPTED)
        begin
            result.client_id_length = cid_len_next;
            result.username_length  = flags_next[FLAG_USER] ? user_len_next : 16'd0;
            result.has_username     = flags_next[FLAG_USER];
        end
        else
        begin
            result.client_id_length = '0;
            result.username_length  = '0;
            result.has_username     = 1'b0;
        end
    end

    // stream state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_TYPE;
            total_reg    <= '0;
            rlen_reg     <= '0;
            body_reg     <= '0;
            shift_reg    <= '0;
            field_reg    <= '0;
            flags_reg    <= '0;
            v5_reg       <= 1'b0;
            cid_len_reg  <= '0;
            user_len_reg <= '0;
            outcome_reg  <= OUTCOME_PARSING;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            total_reg    <= total_next;
            rlen_reg     <= rlen_next;
            body_reg     <= body_next;
            shift_reg    <= shift_next;
            field_reg    <= field_next;
            flags_reg    <= flags_next;
            v5_reg       <= v5_next;
            cid_len_reg  <= cid_len_next;
            user_len_reg <= user_len_next;
            outcome_reg  <= outcome_next;
        end
    end

    // checks
    a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(phase_reg))
        else $error("parse phase not one-hot");

    a_total_sat: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= MIN_BYTES)
        else $error("byte count beyond saturation");

    a_done_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DONE) == (outcome_reg != OUTCOME_PARSING))
        else $error("done phase and outcome disagree");

    a_bad_type: assert property (@(posedge clk) disable iff (!rst_n)
        accept && first_byte && data_byte != CONNECT_TYPE
        |=> phase_reg == PH_DONE && outcome_reg == OUTCOME_ERR_HEAD)
        else $error("bad type byte not rejected");

endmodule

// ----- design/mqtt_cs_outreg.sv -----
// result register between the parser and the output channel
module mqtt_cs_outreg
    import mqtt_cs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t load_data,
    input  logic    out_ready,
    output logic    out_valid,
    output result_t out_data,
    output logic    in_ready
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    // free when empty or when the held result leaves this cycle
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> in_ready)
        else $error("result loaded while register full");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> valid_reg && data_reg == $past(load_data))
        else $error("loaded result not presented");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !out_ready |=> valid_reg && $stable(data_reg))
        else $error("stalled result lost");

endmodule

// ----- design/mqtt_connect_sniffer.sv -----
// top level of the mqtt connect sniffer
// Usage:
//   in_ch carries one byte of a connection per transfer, with first_byte
//   marking the start of a new connection (the parser restarts on it) and
//   end_of_data marking the last byte currently buffered.
//   out_ch carries exactly one result per input byte, in order: the byte
//   itself, its role (client id, username or other) and, on an
//   end_of_data byte, the verdict and, if accepted, the client id and username lengths.
//   cfg_write_en/cfg_write_data set the enable bit; write it only while idle.
// Timing: a result is registered and presented on out_ch in the cycle after its byte transfer.
// Throughput: one byte per cycle while out_ch takes results; every byte takes a single update of the
//   parse state, done between the stream state registers and the result
//   register.
// Reset: clears the enable bit (every verdict is declined until it is set),
//   empties the result register and leaves the parser expecting a type byte.
// Stall: while out_ch is held off, the result stays in place and in_ch
//   ready falls; ready rises again in the cycle the result is taken.
module mqtt_connect_sniffer
    import mqtt_cs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_write_en,
    input  logic         cfg_write_data,
    mqtt_cs_in_if.sink   in_ch,
    mqtt_cs_out_if.source out_ch
);

    logic    accept;
    logic    in_ready;
    logic    out_valid;
    result_t result;
    result_t out_data;

    assign in_ch.ready = in_ready;
    assign accept      = in_ch.valid && in_ready;

    mqtt_cs_parser u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .accept         (accept),
        .data_byte      (in_ch.data_byte),
        .first_byte     (in_ch.first_byte),
        .end_of_data    (in_ch.end_of_data),
        .result         (result)
    );

    mqtt_cs_outreg u_outreg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .load_data (result),
        .out_ready (out_ch.ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .in_ready  (in_ready)
    );

    // output channel
    assign out_ch.valid            = out_valid;
    assign out_ch.verdict          = out_data.verdict;
    assign out_ch.byte_role        = out_data.byte_role;
    assign out_ch.out_byte         = out_data.out_byte;
    assign out_ch.client_id_length = out_data.client_id_length;
    assign out_ch.username_length  = out_data.username_length;
    assign out_ch.has_username     = out_data.has_username;

endmodule

// ----- tb/mqtt_connect_sniffer_tb.sv -----
// self-checking testbench for the mqtt connect sniffer: byte streams in, one checked result out
module mqtt_connect_sniffer_tb;
    import mqtt_cs_pkg::*;

    localparam int          LIMIT         = 200000;
    localparam int          LONG_HOLD     = 300;
    localparam int          HOLD_AT       = 120;
    localparam int          PRINT_CAP     = 30;
    localparam int unsigned PASSWORD_FLAG = 6;
    localparam logic [31:0] PROTO_NAME    = 32'h4D51_5454;

    // tracks the parser state of the stream and queues the result of every byte
    class connect_scoreboard;
        bit          enable;
        phase_t      phase;
        logic [3:0]  byte_total;
        logic [27:0] rem_len;
        logic [27:0] body_len;
        logic [27:0] field_cnt;
        logic [1:0]  digit_pos;
        logic [7:0]  flags;
        logic        v5;
        logic [15:0] cid_len;
        logic [15:0] user_len;
        logic [1:0]  outcome;
        result_t     expected_q[$];
        int          errors;
        int          checked;
        int          n_accepted;
        int          n_declined;
        int          n_needmore;

        function new();
            enable     = 1'b0;
            errors     = 0;
            checked    = 0;
            n_accepted = 0;
            n_declined = 0;
            n_needmore = 0;
            restart();
        endfunction

        function void restart();
            phase      = PH_TYPE;
            byte_total = '0;
            rem_len    = '0;
            body_len   = '0;
            field_cnt  = '0;
            digit_pos  = '0;
            flags      = '0;
            v5         = 1'b0;
            cid_len    = '0;
            user_len   = '0;
            outcome    = OUTCOME_PARSING;
        endfunction

        function void stop(logic [1:0] code);
            outcome = code;
            phase   = PH_DONE;
        endfunction

        function void start_varint(phase_t next);
            field_cnt = '0;
            digit_pos = '0;
            phase     = next;
        endfunction

        // 1 on the last digit, 0 to go on, -1 when a fourth digit still continues
        function int varint_digit(logic [7:0] b, inout logic [27:0] acc);
            logic [27:0] digit;
            digit = {21'd0, b[6:0]} << (7 * digit_pos);
            acc   = acc + digit;
            if (!b[7])
                return 1;
            if (digit_pos == VARINT_LAST)
                return -1;
            digit_pos = digit_pos + 2'd1;
            return 0;
        endfunction

        function void after_client_id();
            if (!flags[FLAG_USER])
                stop(OUTCOME_COMPLETE);
            else if (flags[FLAG_WILL])
            begin
                if (v5)
                    start_varint(PH_WPLEN);
                else
                    phase = PH_WT_HI;
            end
            else
                phase = PH_UN_HI;
        endfunction

        function void string_end(phase_t body_ph);
            case (body_ph)
                PH_CID:  after_client_id();
                PH_WT:   phase = PH_WP_HI;
                PH_WP:   phase = PH_UN_HI;
                default: stop(OUTCOME_COMPLETE);
            endcase
        endfunction

        // advance the parser by one byte and queue the result it yields
        function void note_byte(logic [7:0] b, logic first, logic eod);
            result_t    r;
            phase_t     ph;
            logic [1:0] role;
            logic [1:0] verdict;
            int         st;
            role    = ROLE_OTHER;
            verdict = VERDICT_PENDING;
            if (first)
                restart();
            if (byte_total < MIN_BYTES)
                byte_total++;
            if (phase != PH_TYPE && phase != PH_RLEN && body_len != COUNT_MAX)
                body_len++;

            ph = phase;
            case (ph)
                PH_TYPE:
                    if (b != CONNECT_TYPE)
                        stop(OUTCOME_ERR_HEAD);
                    else
                    begin
                        rem_len   = '0;
                        digit_pos = '0;
                        phase     = PH_RLEN;
                    end
                PH_RLEN:
                begin
                    st = varint_digit(b, rem_len);
                    if (st < 0)
                        stop(OUTCOME_ERR_HEAD);
                    else if (st > 0)
                        phase = PH_PN_HI;
                end
                PH_PN_HI:
                    if (b != 8'h00)
                        stop(OUTCOME_ERR_BODY);
                    else
                        phase = PH_PN_LO;
                PH_PN_LO:
                    if (b != NAME_LEN)
                        stop(OUTCOME_ERR_BODY);
                    else
                    begin
                        field_cnt = '0;
                        phase     = PH_PN;
                    end
                PH_PN:
                    if (b != PROTO_NAME[31 - 8 * field_cnt[1:0] -: 8])
                        stop(OUTCOME_ERR_BODY);
                    else
                    begin
                        field_cnt++;
                        if (field_cnt >= 4)
                            phase = PH_VER;
                    end
                PH_VER:
                    if (b == VERSION_311)
                    begin
                        v5    = 1'b0;
                        phase = PH_FLAGS;
                    end
                    else if (b == VERSION_5)
                    begin
                        v5    = 1'b1;
                        phase = PH_FLAGS;
                    end
                    else
                        stop(OUTCOME_ERR_BODY);
                PH_FLAGS:
                begin
                    flags = b;
                    if (b[FLAG_RESERVED])
                        stop(OUTCOME_ERR_BODY);
                    else
                    begin
                        field_cnt = '0;
                        phase     = PH_KA;
                    end
                end
                PH_KA:
                begin
                    field_cnt++;
                    if (field_cnt >= 2)
                    begin
                        if (v5)
                            start_varint(PH_PLEN);
                        else
                            phase = PH_CID_HI;
                    end
                end
                PH_PLEN, PH_WPLEN:
                begin
                    st = varint_digit(b, field_cnt);
                    if (st < 0)
                        stop(OUTCOME_ERR_BODY);
                    else if (st > 0)
                    begin
                        if (ph == PH_PLEN)
                            phase = (field_cnt == 0) ? PH_CID_HI : PH_PSKIP;
                        else
                            phase = (field_cnt == 0) ? PH_WT_HI : PH_WPSKIP;
                    end
                end
                PH_PSKIP, PH_WPSKIP:
                begin
                    field_cnt--;
                    if (field_cnt == 0)
                        phase = (ph == PH_PSKIP) ? PH_CID_HI : PH_WT_HI;
                end
                PH_CID_HI, PH_WT_HI, PH_WP_HI, PH_UN_HI:
                begin
                    field_cnt = {12'd0, b, 8'd0};
                    phase     = phase_t'(ph << 1);
                end
                PH_CID_LO, PH_WT_LO, PH_WP_LO, PH_UN_LO:
                begin
                    field_cnt = field_cnt | {20'd0, b};
                    if (ph == PH_CID_LO)
                        cid_len = field_cnt[15:0];
                    if (ph == PH_UN_LO)
                        user_len = field_cnt[15:0];
                    if (field_cnt == 0)
                        string_end(phase_t'(ph << 1));
                    else
                        phase = phase_t'(ph << 1);
                end
                PH_CID, PH_WT, PH_WP, PH_UN:
                begin
                    if (ph == PH_CID)
                        role = ROLE_CLIENTID;
                    if (ph == PH_UN)
                        role = ROLE_USERNAME;
                    field_cnt--;
                    if (field_cnt == 0)
                        string_end(ph);
                end
                default:
                    phase = PH_DONE;
            endcase

            // verdict on the last buffered byte
            if (eod)
            begin
                if (!enable)
                    verdict = VERDICT_DECLINED;
                else if (byte_total < MIN_BYTES)
                    verdict = VERDICT_NEEDMORE;
                else if (outcome == OUTCOME_ERR_HEAD)
                    verdict = VERDICT_DECLINED;
                else if (body_len < rem_len)
                    verdict = VERDICT_NEEDMORE;
                else if (outcome == OUTCOME_COMPLETE)
                    verdict = VERDICT_ACCEPTED;
                else
                    verdict = VERDICT_DECLINED;
                if (verdict == VERDICT_ACCEPTED)
                    n_accepted++;
                else if (verdict == VERDICT_DECLINED)
                    n_declined++;
                else
                    n_needmore++;
            end

            r.verdict          = verdict;
            r.byte_role        = role;
            r.out_byte         = b;
            r.client_id_length = '0;
            r.username_length  = '0;
            r.has_username     = 1'b0;
            if (verdict == VERDICT_ACCEPTED)
            begin
                r.client_id_length = cid_len;
                r.has_username     = flags[FLAG_USER];
                if (flags[FLAG_USER])
                    r.username_length = user_len;
            end
            expected_q.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= PRINT_CAP)
                $display("mismatch: %s", msg);
        endtask

        // compare one result transfer with the oldest expectation
        task check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0)
            begin
                report($sformatf("result with nothing expected, byte %02h", got.out_byte));
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.verdict !== want.verdict)
                report($sformatf("result %0d verdict got %0d want %0d",
                                 checked, got.verdict, want.verdict));
            if (got.byte_role !== want.byte_role)
                report($sformatf("result %0d byte_role got %0d want %0d",
                                 checked, got.byte_role, want.byte_role));
            if (got.out_byte !== want.out_byte)
                report($sformatf("result %0d out_byte got %02h want %02h",
                                 checked, got.out_byte, want.out_byte));
            if (got.client_id_length !== want.client_id_length)
                report($sformatf("result %0d client_id_length got %0d want %0d",
                                 checked, got.client_id_length, want.client_id_length));
            if (got.username_length !== want.username_length)
                report($sformatf("result %0d username_length got %0d want %0d",
                                 checked, got.username_length, want.username_length));
            if (got.has_username !== want.has_username)
                report($sformatf("result %0d has_username got %0d want %0d",
                                 checked, got.has_username, want.has_username));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_write_en;
    logic cfg_write_data;

    mqtt_cs_in_if  in_ch();
    mqtt_cs_out_if out_ch();

    connect_scoreboard sb;
    int burst_left  = 0;
    int bytes_sent  = 0;
    int streams     = 0;
    int cycle_count = 0;

    mqtt_connect_sniffer dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_ch          (in_ch),
        .out_ch         (out_ch)
    );

    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("mqtt_connect_sniffer test failed");
            $finish;
        end
    end

    // variable-length integer, optionally padded with continued zero digits
    function automatic void put_varint(ref logic [7:0] q[$], input int unsigned v,
                                       input int extra);
        int         n;
        int         total;
        logic [7:0] d;
        n = 1;
        while (n < 4 && (v >> (7 * n)) != 0)
            n++;
        total = (n + extra > 4) ? 4 : n + extra;
        for (int i = 0; i < total; i++)
        begin
            d = 8'((v >> (7 * i)) & 32'h7F);
            if (i < total - 1)
                d[7] = 1'b1;
            q.push_back(d);
        end
    endfunction

    // mostly short strings, now and then one past 255 bytes
    function automatic int pick_len();
        int r;
        r = $urandom_range(39, 0);
        if (r == 0)
            return $urandom_range(257, 256);
        if (r < 8)
            return $urandom_range(12, 5);
        return $urandom_range(4, 0);
    endfunction

    function automatic void put_string(ref logic [7:0] q[$], input int len);
        q.push_back(8'(len >> 8));
        q.push_back(8'(len));
        repeat (len) q.push_back(8'($urandom));
    endfunction

    function automatic void put_props(ref logic [7:0] q[$]);
        int len;
        len = ($urandom_range(19, 0) == 0) ? $urandom_range(130, 128) : $urandom_range(5, 0);
        put_varint(q, len, ($urandom_range(7, 0) == 0) ? 1 : 0);
        repeat (len) q.push_back(8'($urandom));
    endfunction

    // connect packet with random content, sometimes with a bad length or a broken byte
    function automatic void build_connect(ref logic [7:0] q[$]);
        logic [7:0]  body[$];
        logic [7:0]  flg;
        logic        v5;
        int unsigned rlen;
        v5  = 1'($urandom_range(1, 0));
        flg = 8'($urandom) & 8'hFE;
        if ($urandom_range(15, 0) == 0)
            flg[FLAG_RESERVED] = 1'b1;
        body = '{8'h00, NAME_LEN, PROTO_NAME[31:24], PROTO_NAME[23:16],
                 PROTO_NAME[15:8], PROTO_NAME[7:0]};
        if ($urandom_range(15, 0) == 0)
            body.push_back(8'($urandom));
        else
            body.push_back(v5 ? VERSION_5 : VERSION_311);
        body.push_back(flg);
        body.push_back(8'($urandom));
        body.push_back(8'($urandom));
        if (v5)
            put_props(body);
        put_string(body, pick_len());
        if (flg[FLAG_WILL])
        begin
            if (v5)
                put_props(body);
            put_string(body, pick_len());
            put_string(body, pick_len());
        end
        if (flg[FLAG_USER])
            put_string(body, pick_len());
        if (flg[PASSWORD_FLAG])
            put_string(body, pick_len());

        // remaining length, mostly exact
        rlen = body.size();
        case ($urandom_range(19, 0))
            0, 1:    rlen = rlen + $urandom_range(20, 1);
            2, 3:    rlen = $urandom_range(rlen, 0);
            4:       rlen = $urandom & 32'h0FFF_FFFF;
            default: rlen = rlen;
        endcase

        q.delete();
        q.push_back(CONNECT_TYPE);
        if ($urandom_range(15, 0) == 0)
            repeat (4) q.push_back(8'($urandom) | 8'h80);
        else
            put_varint(q, rlen, ($urandom_range(7, 0) == 0) ? $urandom_range(3, 1) : 0);
        foreach (body[i])
            q.push_back(body[i]);
        if ($urandom_range(7, 0) == 0)
            q[$urandom_range(q.size() - 1, 0)] = 8'($urandom);
    endfunction

    // offer one byte, in bursts with random gaps, and note it once transferred
    task automatic send_byte(input logic [7:0] b, input logic first, input logic eod);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
            if (gap != 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(7, 0) == 0) ? 40 : $urandom_range(12, 1);
        end
        burst_left--;
        in_ch.valid       <= 1'b1;
        in_ch.data_byte   <= b;
        in_ch.first_byte  <= first;
        in_ch.end_of_data <= eod;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_byte(b, first, eod);
        bytes_sent++;
    endtask

    // one stream: mostly a connect packet, sometimes cut short, padded or pure noise
    task automatic send_stream();
        logic [7:0] q[$];
        int         cut;
        int         k;
        logic       first;
        streams++;
        if ($urandom_range(7, 0) == 0)
        begin
            k = $urandom_range(20, 1);
            repeat (k)
                send_byte(8'($urandom), $urandom_range(3, 0) == 0, $urandom_range(3, 0) == 0);
            return;
        end
        build_connect(q);
        if ($urandom_range(3, 0) == 0)
        begin
            k = $urandom_range(5, 1);
            repeat (k) q.push_back(8'($urandom));
        end
        cut = q.size();
        if ($urandom_range(5, 0) == 0)
            cut = $urandom_range(q.size(), 1);
        first = ($urandom_range(7, 0) != 0);
        for (int i = 0; i < cut; i++)
            send_byte(q[i], first && i == 0, i == cut - 1 || $urandom_range(9, 0) == 0);
    endtask

    task automatic run_streams(input int n_bytes);
        int stop_at;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
            send_stream();
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic set_enable(input bit v);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        @(posedge clk);
        sb.enable = v;
        cfg_write_en <= 1'b0;
    endtask

    // result side: stall pattern, one long hold-off, check on every transfer
    initial
    begin
        int          hold_cnt;
        bit          hold_done;
        int          mode_timer;
        logic [15:0] mask;
        logic [3:0]  tick;
        result_t     got;
        hold_cnt     = 0;
        hold_done    = 1'b0;
        mode_timer   = 0;
        mask         = 16'hFFFF;
        tick         = '0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                got.verdict          = out_ch.verdict;
                got.byte_role        = out_ch.byte_role;
                got.out_byte         = out_ch.out_byte;
                got.client_id_length = out_ch.client_id_length;
                got.username_length  = out_ch.username_length;
                got.has_username     = out_ch.has_username;
                sb.check_result(got);
            end
            if (mode_timer == 0)
            begin
                mode_timer = 64;
                case ($urandom_range(2, 0))
                    0:       mask = 16'hFFFF;
                    1:       mask = 16'($urandom);
                    default: mask = 16'($urandom & $urandom & $urandom);
                endcase
                mask[0] = 1'b1;
            end
            mode_timer--;
            tick++;
            if (hold_cnt != 0)
            begin
                hold_cnt--;
                out_ch.ready <= 1'b0;
            end
            else if (!hold_done && sb.checked >= HOLD_AT)
            begin
                hold_done    = 1'b1;
                hold_cnt     = LONG_HOLD;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= mask[tick];
        end
    end

    // main sequence
    initial
    begin
        logic [7:0] seq[$];
        rst_n             = 1'b0;
        cfg_write_en      = 1'b0;
        cfg_write_data    = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.data_byte   = '0;
        in_ch.first_byte  = 1'b0;
        in_ch.end_of_data = 1'b0;
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // smallest v3.1.1 connect straight after reset, no first_byte, block still disabled
        seq = '{CONNECT_TYPE, 8'h0C, 8'h00, NAME_LEN, PROTO_NAME[31:24], PROTO_NAME[23:16],
                PROTO_NAME[15:8], PROTO_NAME[7:0], VERSION_311, 8'h02, 8'h00, 8'h3C,
                8'h00, 8'h00};
        for (int i = 0; i < seq.size(); i++)
            send_byte(seq[i], 1'b0, i == seq.size() - 1);
        drain();

        // enable mid-stream, then bytes after completion
        set_enable(1'b1);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1);

        // remaining length that never ends
        send_byte(CONNECT_TYPE, 1'b1, 1'b0);
        repeat (3) send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b1);

        run_streams(300);
        drain();
        set_enable(1'b0);
        run_streams(50);
        drain();
        set_enable(1'b1);
        run_streams(110);
        drain();
        repeat (5) @(posedge clk);

        if (sb.expected_q.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));
        $display("sent %0d bytes in %0d streams, checked %0d results, %0d mismatches",
                 bytes_sent, streams, sb.checked, sb.errors);
        $display("verdicts seen: %0d accepted, %0d declined, %0d need-more",
                 sb.n_accepted, sb.n_declined, sb.n_needmore);
        if (sb.errors == 0)
            $display("mqtt_connect_sniffer test passed");
        else
            $display("mqtt_connect_sniffer test failed");
        $finish;
    end

endmodule
